// ===== rtl/core/stt_pkg.sv =====
// Shared types and codes for the software timer table.
// No dependencies; imported by software_timer_table and the testbench.
`timescale 1ns / 1ps
package stt_pkg;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_POOL_FULL = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  task_id;
    logic [7:0]  signal_code;
    logic [31:0] duration;
    logic        periodic;
    logic [31:0] elapsed;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [7:0]  expired_task;
    logic [7:0]  expired_signal;
    logic [4:0]  free_slots;
    logic        last;
  } rsp_t;

  // Timer entry body; the list link is kept beside it in the same memory word.
  typedef struct packed {
    logic [7:0]  task_id;
    logic [7:0]  signal_code;
    logic [31:0] count;
    logic [31:0] period;
  } ent_t;

endpackage

// ===== rtl/core/stt_ram.sv =====
// Single-port-write, single-port-read entry memory with registered read data.
// Depends on nothing; instantiated by software_timer_table.
`timescale 1ns / 1ps
module stt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 85,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/software_timer_table.sv =====
// Software timer table: set, remove and tick over a linked list of timers.
// Each step reads one entry (S_RD), then evaluates or writes it (S_EV); a tick
// walks every live entry and waits in S_EV while results are stalled.
// Throughput: one transaction at a time; the read-then-write walk of the entry
// memory (one read port, registered read data) sets the rate.
// Reset: synchronous; clears valid bits, list head, count and sequencer.
`timescale 1ns / 1ps
module software_timer_table
  import stt_pkg::*;
#(
  parameter int POOL_SIZE = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Index width holds the empty marker (POOL_SIZE); address width only slots.
  localparam int IW = $clog2(POOL_SIZE + 1);
  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int WW = IW + $bits(ent_t);
  localparam logic [IW-1:0] NONE = IW'(POOL_SIZE);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_STAT = 3'd4;

  logic [2:0]          state;
  req_t                cmd;
  logic [IW-1:0]       cur;
  logic [IW-1:0]       prev;
  ent_t                prev_ent;
  logic [IW-1:0]       guard;
  logic [1:0]          stat;
  logic [POOL_SIZE-1:0] valid;
  logic [IW-1:0]       first;
  logic [IW-1:0]       used;

  // Memory port signals
  logic            we;
  logic [AW-1:0]   waddr;
  logic [WW-1:0]   wdata;
  logic            re;
  logic [WW-1:0]   rdata;
  ent_t            rent;
  logic [IW-1:0]   rlink;

  assign rent  = rdata[$bits(ent_t)-1:0];
  assign rlink = rdata[WW-1:$bits(ent_t)];

  stt_ram #(.DEPTH(POOL_SIZE), .WIDTH(WW), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (cur[AW-1:0]),
    .rdata (rdata)
  );

  // Output register is free when empty or being drained this cycle.
  logic ofree;
  assign ofree = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  // Walk condition and per-entry evaluation
  logic walk_on;
  assign walk_on = (cur < NONE) && (guard < NONE);

  logic        match;
  logic [31:0] dec_count;
  logic        hit_zero;
  logic        free_it;
  ent_t        upd_ent;
  assign match     = (rent.task_id == cmd.task_id) && (rent.signal_code == cmd.signal_code);
  assign dec_count = (cmd.elapsed < rent.count) ? (rent.count - cmd.elapsed) : 32'd0;
  assign hit_zero  = (dec_count == 32'd0);
  assign free_it   = hit_zero && (rent.period == 32'd0);

  always_comb begin
    upd_ent = rent;
    if (cmd.op == OP_SET) begin
      upd_ent.count = cmd.duration;
    end else if (hit_zero) begin
      upd_ent.count = rent.period;
    end else begin
      upd_ent.count = dec_count;
    end
  end

  // Lowest free slot
  logic          slot_found;
  logic [AW-1:0] slot;
  always_comb begin
    slot_found = 1'b0;
    slot       = '0;
    for (int i = POOL_SIZE - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        slot_found = 1'b1;
        slot       = AW'(i);
      end
    end
  end

  ent_t new_ent;
  always_comb begin
    new_ent.task_id     = cmd.task_id;
    new_ent.signal_code = cmd.signal_code;
    new_ent.count       = cmd.duration;
    new_ent.period      = cmd.periodic ? cmd.duration : 32'd0;
  end

  // Memory write selection: one write per cycle at most.
  logic unlink;
  assign unlink = (state == S_EV) &&
                  (((cmd.op == OP_REMOVE) && match) ||
                   ((cmd.op == OP_TICK) && ofree && free_it));

  always_comb begin
    we    = 1'b0;
    waddr = cur[AW-1:0];
    wdata = {rlink, upd_ent};
    re    = (state == S_RD) && walk_on;
    if (unlink) begin
      // Patch the predecessor link; head updates go to the first register.
      we    = (prev != NONE);
      waddr = prev[AW-1:0];
      wdata = {rlink, prev_ent};
    end else if (state == S_EV) begin
      we = ((cmd.op == OP_SET) && match) || ((cmd.op == OP_TICK) && ofree);
    end else if (state == S_ADD) begin
      we    = slot_found;
      waddr = slot;
      wdata = {first, new_ent};
    end
  end

  logic [IW-1:0] used_dec;
  assign used_dec = used - IW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      first     <= NONE;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (unlink) begin
        valid[cur[AW-1:0]] <= 1'b0;
        used <= used_dec;
        if (prev == NONE) begin
          first <= rlink;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd   <= req;
            cur   <= first;
            prev  <= NONE;
            guard <= '0;
            stat  <= STATUS_OK;
            if ((req.op == OP_SET) || (req.op == OP_REMOVE) || (req.op == OP_TICK)) begin
              state <= S_RD;
            end else begin
              state <= S_STAT;
            end
          end
        end
        S_RD: begin
          if (walk_on) begin
            state <= S_EV;
          end else if (cmd.op == OP_SET) begin
            state <= S_ADD;
          end else begin
            stat  <= (cmd.op == OP_REMOVE) ? STATUS_NOT_FOUND : STATUS_OK;
            state <= S_STAT;
          end
        end
        S_EV: begin
          if (cmd.op != OP_TICK) begin
            if (match) begin
              state <= S_STAT;
            end else begin
              prev      <= cur;
              prev_ent  <= rent;
              cur       <= rlink;
              guard     <= guard + IW'(1);
              state     <= S_RD;
            end
          end else if (ofree) begin
            // Apply the tick to this entry and emit an expiry on zero.
            if (!free_it) begin
              prev      <= cur;
              prev_ent  <= upd_ent;
            end
            if (hit_zero) begin
              rsp_valid          <= 1'b1;
              rsp.kind           <= KIND_EXPIRY;
              rsp.status         <= STATUS_OK;
              rsp.expired_task   <= rent.task_id;
              rsp.expired_signal <= rent.signal_code;
              rsp.free_slots     <= 5'(IW'(POOL_SIZE) - (free_it ? used_dec : used));
              rsp.last           <= 1'b0;
            end
            cur   <= rlink;
            guard <= guard + IW'(1);
            state <= S_RD;
          end
        end
        S_ADD: begin
          if (slot_found) begin
            valid[slot] <= 1'b1;
            first       <= IW'(slot);
            used        <= used + IW'(1);
          end else begin
            stat <= STATUS_POOL_FULL;
          end
          state <= S_STAT;
        end
        S_STAT: begin
          if (ofree) begin
            rsp_valid          <= 1'b1;
            rsp.kind           <= KIND_STATUS;
            rsp.status         <= stat;
            rsp.expired_task   <= 8'd0;
            rsp.expired_signal <= 8'd0;
            rsp.free_slots     <= 5'(IW'(POOL_SIZE) - used);
            rsp.last           <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // Live count tracks the valid bits.
  a_used_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used))
    else $error("used count out of step with valid bits");

  // Status items close a step; expiries never do.
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.last == (rsp.kind == KIND_STATUS)))
    else $error("last flag disagrees with result kind");

  // Empty head means an empty table.
  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((first == NONE) == (used == '0)))
    else $error("list head and used count disagree");
`endif

endmodule

// ===== tb/software_timer_table_test.sv =====
// Testbench for software_timer_table: directed and random set/remove/tick
// traffic checked against a behavioral timer list. Depends on stt_pkg and software_timer_table.
`timescale 1ns / 1ps
module software_timer_table_test;
  import stt_pkg::*;

  localparam int POOL = 16;
  localparam int NONE = POOL;
  localparam int REQ_W = $bits(req_t);

  // Expected-result store plus the behavioral timer list it is fed from.
  class timer_scoreboard;
    logic [7:0]  t_task [POOL];
    logic [7:0]  t_sig [POOL];
    logic [31:0] t_count [POOL];
    logic [31:0] t_period [POOL];
    bit          t_live [POOL];
    int          t_link [POOL];
    int          head;
    int          used;
    rsp_t        pending [$];
    int          errors;
    int          expiries;

    function void clear();
      foreach (t_live[i]) t_live[i] = 0;
      head = NONE;
      used = 0;
      errors = 0;
      expiries = 0;
      pending.delete();
    endfunction

    function void push(logic k, logic [1:0] st, logic [7:0] tk, logic [7:0] sg, logic l);
      rsp_t r;
      r.kind = k;
      r.status = st;
      r.expired_task = tk;
      r.expired_signal = sg;
      r.free_slots = 5'(POOL - used);
      r.last = l;
      pending.push_back(r);
    endfunction

    function int find(logic [7:0] tk, logic [7:0] sg, output int prv);
      int cur;
      int p;
      cur = head;
      p = NONE;
      while (cur != NONE) begin
        if (t_task[cur] == tk && t_sig[cur] == sg) begin
          prv = p;
          return cur;
        end
        p = cur;
        cur = t_link[cur];
      end
      prv = NONE;
      return NONE;
    endfunction

    function void unlink(int idx, int prv);
      if (prv != NONE) t_link[prv] = t_link[idx];
      else head = t_link[idx];
      t_live[idx] = 0;
      used--;
    endfunction

    // Note an accepted transaction and queue what it must produce.
    function void note_request(req_t q);
      int idx;
      int prv;
      int cur;
      int nxt;
      bit freed;
      logic [7:0] tk;
      logic [7:0] sg;
      case (q.op)
        OP_SET: begin
          idx = find(q.task_id, q.signal_code, prv);
          if (idx != NONE) begin
            t_count[idx] = q.duration;
            push(KIND_STATUS, STATUS_OK, 0, 0, 1);
          end else begin
            idx = NONE;
            for (int i = POOL - 1; i >= 0; i--) if (!t_live[i]) idx = i;
            if (idx == NONE) begin
              push(KIND_STATUS, STATUS_POOL_FULL, 0, 0, 1);
            end else begin
              t_live[idx] = 1;
              t_task[idx] = q.task_id;
              t_sig[idx] = q.signal_code;
              t_count[idx] = q.duration;
              t_period[idx] = q.periodic ? q.duration : 32'd0;
              t_link[idx] = head;
              head = idx;
              used++;
              push(KIND_STATUS, STATUS_OK, 0, 0, 1);
            end
          end
        end
        OP_REMOVE: begin
          idx = find(q.task_id, q.signal_code, prv);
          if (idx != NONE) begin
            unlink(idx, prv);
            push(KIND_STATUS, STATUS_OK, 0, 0, 1);
          end else begin
            push(KIND_STATUS, STATUS_NOT_FOUND, 0, 0, 1);
          end
        end
        OP_TICK: begin
          cur = head;
          prv = NONE;
          while (cur != NONE) begin
            nxt = t_link[cur];
            freed = 0;
            t_count[cur] = (q.elapsed < t_count[cur]) ? t_count[cur] - q.elapsed : 32'd0;
            if (t_count[cur] == 0) begin
              tk = t_task[cur];
              sg = t_sig[cur];
              if (t_period[cur] != 0) t_count[cur] = t_period[cur];
              else begin
                unlink(cur, prv);
                freed = 1;
              end
              push(KIND_EXPIRY, STATUS_OK, tk, sg, 0);
              expiries++;
            end
            if (!freed) prv = cur;
            cur = nxt;
          end
          push(KIND_STATUS, STATUS_OK, 0, 0, 1);
        end
        default: push(KIND_STATUS, STATUS_OK, 0, 0, 1);
      endcase
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(rsp_t got);
      rsp_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.kind !== exp_r.kind) begin
        $error("kind: expected %0d actual %0d", exp_r.kind, got.kind); errors++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d actual %0d", exp_r.status, got.status); errors++;
      end
      if (got.expired_task !== exp_r.expired_task) begin
        $error("expired_task: expected %0d actual %0d", exp_r.expired_task,
               got.expired_task); errors++;
      end
      if (got.expired_signal !== exp_r.expired_signal) begin
        $error("expired_signal: expected %0d actual %0d", exp_r.expired_signal,
               got.expired_signal); errors++;
      end
      if (got.free_slots !== exp_r.free_slots) begin
        $error("free_slots: expected %0d actual %0d", exp_r.free_slots,
               got.free_slots); errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d actual %0d", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  timer_scoreboard board = new();
  bit quiet = 0;        // final stretch: no idling on either side
  int hold_off = 0;     // long receiver stall, counted in the sink process
  int sent = 0;
  int result_count = 0;

  software_timer_table #(.POOL_SIZE(POOL)) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample results at the rising edge; check only accepted transactions.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      board.check_result(rsp);
      result_count++;
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when asked.
  initial begin
    int burst;
    @(negedge clk);
    forever begin
      if (hold_off > 0) begin
        rsp_stall <= 1'b1;
        hold_off--;
        @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 3);
        rsp_stall <= 1'b1;
        repeat (burst) @(negedge clk);
      end else begin
        rsp_stall <= 1'b0;
        @(negedge clk);
      end
    end
  end

  // Offer one transaction and hold it until accepted; optional gap first.
  // Valid drops at the falling edge after acceptance and stays low for that cycle.
  task automatic send(req_t item);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(item);
    sent++;
    @(negedge clk);
    req_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic req_t make(logic [1:0] op, logic [7:0] tk, logic [7:0] sg,
                                logic [31:0] dur, logic per, logic [31:0] el);
    req_t r;
    r.op = op; r.task_id = tk; r.signal_code = sg;
    r.duration = dur; r.periodic = per; r.elapsed = el;
    return r;
  endfunction

  // Random transaction over a small key space so sets, removes and ticks meet.
  function automatic req_t random_item(int keys);
    req_t r;
    int pick;
    r = req_t'(REQ_W'({$urandom, $urandom, $urandom}));
    r.task_id = 8'($urandom_range(0, keys - 1));
    r.signal_code = 8'($urandom_range(0, 1)) ^ {$urandom_range(0, 1) ? 8'hFF : 8'h00};
    if ($urandom_range(0, 9) == 0) r.task_id = ~r.task_id;
    pick = $urandom_range(0, 19);
    if (pick < 9) r.op = OP_SET;
    else if (pick < 13) r.op = OP_REMOVE;
    else if (pick < 19) r.op = OP_TICK;
    else r.op = 2'd3;
    if ($urandom_range(0, 5) != 0) r.duration = $urandom_range(0, 40);
    if ($urandom_range(0, 5) != 0) r.elapsed = $urandom_range(0, 15);
    return r;
  endfunction

  initial begin
    board.clear();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty tick, misses, full table, reloads, expiry paths.
    send(make(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send(make(OP_REMOVE, 8'hFF, 8'hFF, 0, 0, 0));
    send(make(2'd3, 8'h5A, 8'hA5, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF));
    for (int i = 0; i < POOL; i++)
      send(make(OP_SET, 8'(i), 8'(255 - i), 32'(i + 1), i[0], 0));
    send(make(OP_SET, 8'hFF, 8'h00, 5, 1, 0));                 // full, no match
    send(make(OP_SET, 8'd3, 8'd252, 32'hFFFF_FFFF, 0, 0));    // reload while full
    send(make(OP_SET, 8'd0, 8'd255, 0, 1, 0));                // match keeps period
    send(make(OP_TICK, 0, 0, 0, 0, 32'd0));                   // zero elapsed
    send(make(OP_TICK, 0, 0, 0, 0, 32'd4));
    send(make(OP_REMOVE, 8'd7, 8'd248, 0, 0, 0));
    send(make(OP_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF));           // all reach zero
    wait_drained();

    // Long receiver hold-off while the sender keeps pushing.
    hold_off = 60;
    for (int i = 0; i < 8; i++) send(random_item(6));

    // Random body; the sender pauses until drained once midway.
    for (int n = 0; n < 300; n++) begin
      if (n == 150) wait_drained();
      if (n == 260) quiet = 1;
      send(random_item(n < 100 ? 4 : 20));
    end
    wait_drained();
    repeat (80) @(negedge clk);

    $display("Run covered %0d transactions, %0d results, %0d timer expiries.",
             sent, result_count, board.expiries);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== software_timer_table.f =====
rtl/core/stt_pkg.sv
rtl/core/stt_ram.sv
rtl/core/software_timer_table.sv
tb/software_timer_table_test.sv
